[rtl/ecgqrs_pkg.sv]
package ecgqrs_pkg;

    localparam int WINDOW_DEF = 60;
    localparam int SIG_W      = 32;
    localparam int EN_W       = 40;
    localparam int SUM_W      = 48;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int ACC_W      = 66;
    localparam int COEF_FRAC  = 28;
    localparam int Q_FRAC     = 16;
    localparam int RR_W       = 16;
    localparam int IDX_W      = 32;
    localparam int NTAPS      = 7;
    localparam int TAP_W      = 3;
    localparam int DIV_CYCLES = 4;
    localparam int CFG_AW     = 2;

    localparam logic [1:0] CLS_NOISE    = 2'd0;
    localparam logic [1:0] CLS_FETAL    = 2'd1;
    localparam logic [1:0] CLS_MATERNAL = 2'd2;

    localparam logic [CFG_AW-1:0] REG_NOISE    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FETAL    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MATERNAL = 2'd2;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MAC,
        F_ROUND,
        F_DERIV,
        F_SQ,
        F_SQOUT
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM1,
        B_DIV1,
        B_SUM2,
        B_DIV2,
        B_CLS1,
        B_CLS2
    } back_state_t;

    typedef struct packed {
        logic [EN_W-1:0] noise;
        logic [EN_W-1:0] fetal;
        logic [EN_W-1:0] maternal;
    } centroids_t;

    typedef struct packed {
        logic [EN_W-1:0] energy;
        logic            peak_found;
        logic [1:0]      peak_class;
        logic [EN_W-1:0] peak_height;
        logic            rr_valid;
        logic [RR_W-1:0] rr_interval;
    } result_t;

    // bandpass taps in Q28, feedback terms already negated
    function automatic logic signed [SIG_W-1:0] bp_coef(input logic [TAP_W-1:0] k);
        logic signed [SIG_W-1:0] c;
        begin
            case (k)
                3'd0:    c = 32'sd206295;
                3'd1:    c = -32'sd412591;
                3'd2:    c = 32'sd206295;
                3'd3:    c = 32'sd1051023372;
                3'd4:    c = -32'sd1544595473;
                3'd5:    c = 32'sd1009810200;
                3'd6:    c = -32'sd247804127;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

[rtl/ecgqrs_ram.sv]
module ecgqrs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ecgqrs_fifo.sv]
module ecgqrs_fifo #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/ecgqrs_front.sv]
module ecgqrs_front
    import ecgqrs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [SIG_W-1:0] sample,
    output logic                    sq_push,
    output logic [EN_W-1:0]         sq_data,
    input  logic                    sq_full
);

    front_state_t state_reg, state_next;
    logic [TAP_W-1:0]         tap_reg;
    logic signed [SIG_W-1:0]  x_reg;
    logic signed [SIG_W-1:0]  bpin_reg  [4];
    logic signed [SIG_W-1:0]  bpout_reg [4];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SIG_W-1:0]  f_reg;
    logic [SIG_W-1:0]         mag_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [SIG_W-1:0]  tap_data;
    logic signed [SIG_W-1:0]  coef;
    logic signed [ACC_W-1:0]  acc_rnd, dsum, dsum_rnd;
    logic signed [SIG_W-1:0]  f_sat, d_sat;
    logic [PROD_W-1:0]        sq_rnd;
    logic [EN_W-1:0]          sq_sat;

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
        begin
            if ((&v[ACC_W-1:SIG_W-1]) || !(|v[ACC_W-1:SIG_W-1]))
            begin
                return v[SIG_W-1:0];
            end
            return v[ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
        end
    endfunction

    // operand select for the shared multiplier; hold the square while the queue is full
    always_comb
    begin
        case (tap_reg)
            3'd0:    tap_data = x_reg;
            3'd1:    tap_data = bpin_reg[1];
            3'd2:    tap_data = bpin_reg[3];
            3'd3:    tap_data = bpout_reg[0];
            3'd4:    tap_data = bpout_reg[1];
            3'd5:    tap_data = bpout_reg[2];
            3'd6:    tap_data = bpout_reg[3];
            default: tap_data = '0;
        endcase
        coef = bp_coef(tap_reg);
        if (state_reg == F_SQ || state_reg == F_SQOUT)
        begin
            mul_a = {1'b0, mag_reg};
            mul_b = {1'b0, mag_reg};
        end
        else
        begin
            mul_a = {coef[SIG_W-1], coef};
            mul_b = {tap_data[SIG_W-1], tap_data};
        end
    end

    always_comb
    begin
        acc_rnd  = (acc_reg + (ACC_W'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        f_sat    = sat_sig(acc_rnd);
        dsum     = ACC_W'(f_reg) + (ACC_W'(bpout_reg[0]) <<< 1)
                 - (ACC_W'(bpout_reg[2]) <<< 1) - ACC_W'(bpout_reg[3]);
        dsum_rnd = (dsum + ACC_W'(2)) >>> 2;
        d_sat    = sat_sig(dsum_rnd);
        sq_rnd   = prod_reg + (PROD_W'(1) << (Q_FRAC - 1));
        if (|sq_rnd[PROD_W-1:EN_W+Q_FRAC])
        begin
            sq_sat = '1;
        end
        else
        begin
            sq_sat = sq_rnd[EN_W+Q_FRAC-1:Q_FRAC];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sq_push    = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    state_next = F_MAC;
                end
            end
            F_MAC:
            begin
                if (tap_reg == TAP_W'(NTAPS))
                begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND: state_next = F_DERIV;
            F_DERIV: state_next = F_SQ;
            F_SQ:    state_next = F_SQOUT;
            F_SQOUT:
            begin
                sq_push = 1'b1;
                if (!sq_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign full    = (state_reg != F_IDLE);
    assign sq_data = sq_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            tap_reg   <= '0;
            acc_reg   <= '0;
            for (int i = 0; i < 4; i++)
            begin
                bpin_reg[i]  <= '0;
                bpout_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                F_IDLE:
                begin
                    tap_reg <= '0;
                    acc_reg <= '0;
                end
                F_MAC:
                begin
                    if (tap_reg != '0)
                    begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    tap_reg <= tap_reg + TAP_W'(1);
                end
                F_ROUND:
                begin
                    bpin_reg[3] <= bpin_reg[2];
                    bpin_reg[2] <= bpin_reg[1];
                    bpin_reg[1] <= bpin_reg[0];
                    bpin_reg[0] <= x_reg;
                end
                F_DERIV:
                begin
                    bpout_reg[3] <= bpout_reg[2];
                    bpout_reg[2] <= bpout_reg[1];
                    bpout_reg[1] <= bpout_reg[0];
                    bpout_reg[0] <= f_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            x_reg <= sample;
        end
        prod_reg <= mul_a * mul_b;
        if (state_reg == F_ROUND)
        begin
            f_reg <= f_sat;
        end
        if (state_reg == F_DERIV)
        begin
            mag_reg <= d_sat[SIG_W-1] ? (~d_sat + SIG_W'(1)) : d_sat;
        end
    end

endmodule

[rtl/ecgqrs_div.sv]
module ecgqrs_div
    import ecgqrs_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int CW = $clog2(DIV_CYCLES);
    localparam int S  = SUM_W + $clog2(WINDOW);
    localparam int HW = SUM_W / 2;
    localparam int MW = SUM_W + 1;
    localparam int ML = MW - HW;
    localparam int PW = 2 * SUM_W + 1;
    localparam logic [63:0]   RECIP_FULL = ((64'd1 << S) + 64'(WINDOW) - 64'd1)
                                         / 64'(WINDOW);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];

    logic             busy_reg, done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [SUM_W-1:0] x_reg;
    logic [PW-1:0]    acc_reg;
    logic [HW-1:0]    op_x;
    logic [ML-1:0]    op_m;
    logic [HW+ML-1:0] pp;
    logic [PW-1:0]    pp_shift;

    // floor(x / WINDOW) as (x * ceil(2^S / WINDOW)) >> S, one partial product per cycle
    always_comb
    begin
        op_x = cnt_reg[0] ? x_reg[SUM_W-1:HW] : x_reg[HW-1:0];
        op_m = cnt_reg[1] ? ML'(RECIP[MW-1:ML]) : RECIP[ML-1:0];
        pp   = op_x * op_m;
        case (cnt_reg)
            2'd0:    pp_shift = PW'(pp);
            2'd1:    pp_shift = PW'(pp) << HW;
            2'd2:    pp_shift = PW'(pp) << ML;
            default: pp_shift = PW'(pp) << (HW + ML);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(DIV_CYCLES - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= dividend;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_shift;
        end
    end

    assign done     = done_reg;
    assign quotient = SUM_W'(acc_reg >> S);

endmodule

[rtl/ecgqrs_back.sv]
module ecgqrs_back
    import ecgqrs_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sq_empty,
    input  logic [EN_W-1:0] sq_data,
    output logic            sq_pop,
    input  centroids_t      cents,
    output logic            res_push,
    output result_t         res_data,
    input  logic            res_full
);

    localparam int PW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);

    back_state_t state_reg, state_next;
    logic [PW-1:0]    ptr_reg;
    logic [FW-1:0]    fill_reg;
    logic [EN_W-1:0]  sq_reg, old2_reg, avg1_reg, e0_reg, e1_reg, e2_reg;
    logic [EN_W-1:0]  dn_reg, df_reg, dm_reg;
    logic [SUM_W-1:0] sum1_reg, sum2_reg, sum1_next, sum2_next;
    logic [IDX_W-1:0] idx_reg, lastf_reg, lastm_reg, gap;
    logic [1:0]       seen_reg;
    logic             peak_reg;

    logic [EN_W-1:0]  rd1, rd2, old1, old2;
    logic             win_full, we1, we2, div_start, div_done;
    logic [SUM_W-1:0] div_q;
    logic [1:0]       cls;
    logic             rv;

    function automatic logic [EN_W-1:0] absdiff(input logic [EN_W-1:0] a,
                                                 input logic [EN_W-1:0] b);
        begin
            return (a >= b) ? (a - b) : (b - a);
        end
    endfunction

    ecgqrs_ram #(.WIDTH(EN_W), .DEPTH(WINDOW)) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (ptr_reg),
        .wdata (sq_reg),
        .raddr (ptr_reg),
        .rdata (rd1)
    );

    ecgqrs_ram #(.WIDTH(EN_W), .DEPTH(WINDOW)) u_ram2 (
        .clk   (clk),
        .we    (we2),
        .waddr (ptr_reg),
        .wdata (avg1_reg),
        .raddr (ptr_reg),
        .rdata (rd2)
    );

    ecgqrs_div #(.WINDOW(WINDOW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ((state_reg == B_SUM1) ? sum1_next : sum2_next),
        .done     (div_done),
        .quotient (div_q)
    );

    // oldest entry counts only once the window has filled
    assign win_full  = (fill_reg == FW'(WINDOW));
    assign old1      = win_full ? rd1 : '0;
    assign old2      = win_full ? rd2 : '0;
    assign sum1_next = sum1_reg - {{(SUM_W-EN_W){1'b0}}, old1} + {{(SUM_W-EN_W){1'b0}}, sq_reg};
    assign sum2_next = sum2_reg - {{(SUM_W-EN_W){1'b0}}, old2_reg}
                     + {{(SUM_W-EN_W){1'b0}}, avg1_reg};

    always_comb
    begin
        if (dn_reg < df_reg && dn_reg < dm_reg)
        begin
            cls = CLS_NOISE;
        end
        else if (df_reg < dn_reg && df_reg < dm_reg)
        begin
            cls = CLS_FETAL;
        end
        else
        begin
            cls = CLS_MATERNAL;
        end
        gap = idx_reg - ((cls == CLS_FETAL) ? lastf_reg : lastm_reg);
        case (cls)
            CLS_FETAL:    rv = seen_reg[0];
            CLS_MATERNAL: rv = seen_reg[1];
            default:      rv = 1'b0;
        endcase
        rv = rv && peak_reg;

        res_data.energy      = e0_reg;
        res_data.peak_found  = peak_reg;
        res_data.peak_class  = peak_reg ? cls : CLS_NOISE;
        res_data.peak_height = peak_reg ? e1_reg : '0;
        res_data.rr_valid    = rv;
        res_data.rr_interval = !rv ? '0 : ((|gap[IDX_W-1:RR_W]) ? '1 : gap[RR_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        sq_pop     = 1'b0;
        res_push   = 1'b0;
        we1        = 1'b0;
        we2        = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!sq_empty)
                begin
                    sq_pop     = 1'b1;
                    state_next = B_SUM1;
                end
            end
            B_SUM1:
            begin
                we1        = 1'b1;
                div_start  = 1'b1;
                state_next = B_DIV1;
            end
            B_DIV1:
            begin
                if (div_done)
                begin
                    state_next = B_SUM2;
                end
            end
            B_SUM2:
            begin
                we2        = 1'b1;
                div_start  = 1'b1;
                state_next = B_DIV2;
            end
            B_DIV2:
            begin
                if (div_done)
                begin
                    state_next = B_CLS1;
                end
            end
            B_CLS1: state_next = B_CLS2;
            B_CLS2:
            begin
                res_push = 1'b1;
                if (!res_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ptr_reg   <= '0;
            fill_reg  <= '0;
            sum1_reg  <= '0;
            sum2_reg  <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
            idx_reg   <= '0;
            lastf_reg <= '0;
            lastm_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_SUM1)
            begin
                sum1_reg <= sum1_next;
            end
            if (state_reg == B_SUM2)
            begin
                sum2_reg <= sum2_next;
            end
            if (state_reg == B_CLS2 && !res_full)
            begin
                e2_reg  <= e1_reg;
                e1_reg  <= e0_reg;
                idx_reg <= idx_reg + IDX_W'(1);
                if (peak_reg && cls == CLS_FETAL)
                begin
                    lastf_reg   <= idx_reg;
                    seen_reg[0] <= 1'b1;
                end
                if (peak_reg && cls == CLS_MATERNAL)
                begin
                    lastm_reg   <= idx_reg;
                    seen_reg[1] <= 1'b1;
                end
                ptr_reg <= (ptr_reg == PW'(WINDOW - 1)) ? '0 : ptr_reg + PW'(1);
                if (!win_full)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            sq_reg <= sq_data;
        end
        if (state_reg == B_SUM1)
        begin
            old2_reg <= old2;
        end
        if (state_reg == B_DIV1 && div_done)
        begin
            avg1_reg <= div_q[EN_W-1:0];
        end
        if (state_reg == B_DIV2 && div_done)
        begin
            e0_reg <= div_q[EN_W-1:0];
        end
        if (state_reg == B_CLS1)
        begin
            peak_reg <= (e1_reg > e2_reg) && (e1_reg >= e0_reg);
            dn_reg   <= absdiff(e1_reg, cents.noise);
            df_reg   <= absdiff(e1_reg, cents.fetal);
            dm_reg   <= absdiff(e1_reg, cents.maternal);
        end
    end

endmodule

[rtl/ecg_qrs_peak_classifier.sv]
// Each half takes one sample at a time; the back end, which runs two reciprocal divisions
//   by WINDOW per sample, limits the sample rate, not the front end's shared multiplier.
// Reset (rst_n, asynchronous, active low): filter history, running sums, window fill,
//   peak history and centroids clear to zero; both queues empty. No clearing pass.
module ecg_qrs_peak_classifier
    import ecgqrs_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // sample queue side
    input  logic                    push,
    output logic                    full,
    input  logic signed [SIG_W-1:0] sample,
    // result queue side
    output logic                    empty,
    input  logic                    pop,
    output logic [EN_W-1:0]         energy,
    output logic                    peak_found,
    output logic [1:0]              peak_class,
    output logic [EN_W-1:0]         peak_height,
    output logic                    rr_valid,
    output logic [RR_W-1:0]         rr_interval,
    // centroid write port
    input  logic                    cfg_we,
    input  logic [CFG_AW-1:0]       cfg_addr,
    input  logic [EN_W-1:0]         cfg_data
);

    centroids_t      cents_reg;
    logic            sq_push, sq_full, sq_empty, sq_pop;
    logic [EN_W-1:0] sq_in, sq_out;
    logic            res_push, res_full;
    result_t         res_in, res_out;

    // Centroid registers: to be written by the user only while idle, unchecked; unknown indexes drop the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cents_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_NOISE:    cents_reg.noise    <= cfg_data;
                REG_FETAL:    cents_reg.fetal    <= cfg_data;
                REG_MATERNAL: cents_reg.maternal <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front end: bandpass (7 taps on one multiplier), derivative, squaring.
    ecgqrs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .sq_push (sq_push),
        .sq_data (sq_in),
        .sq_full (sq_full)
    );

    // Two-entry queue lets the front end take the next sample while the back end works.
    ecgqrs_fifo #(.WIDTH(EN_W)) u_sq_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (sq_push),
        .wdata (sq_in),
        .full  (sq_full),
        .pop   (sq_pop),
        .rdata (sq_out),
        .empty (sq_empty)
    );

    // Back end: two moving averages over RAM windows, peak test, classification, RR.
    ecgqrs_back #(.WINDOW(WINDOW)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .sq_empty (sq_empty),
        .sq_data  (sq_out),
        .sq_pop   (sq_pop),
        .cents    (cents_reg),
        .res_push (res_push),
        .res_data (res_in),
        .res_full (res_full)
    );

    // Result queue: hold finished results until the consumer pops them.
    ecgqrs_fifo #(.WIDTH($bits(result_t))) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign energy      = res_out.energy;
    assign peak_found  = res_out.peak_found;
    assign peak_class  = res_out.peak_class;
    assign peak_height = res_out.peak_height;
    assign rr_valid    = res_out.rr_valid;
    assign rr_interval = res_out.rr_interval;

endmodule
